// ----- design/sha512_pkg.sv -----
// sha512_pkg: constants, types and functions for the sha-512 engine
// no dependencies
package sha512_pkg;

    localparam int ROUNDS = 80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       start;
    } t_core_ctl;

    localparam logic [63:0] IV [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ----- design/sha512_core.sv -----
// sha512_core: one sha-512 round per cycle over a rolling 16-word schedule
// depends on sha512_pkg
module sha512_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha512_pkg::t_core_ctl i_ctl,
    input  logic [63:0]           i_w [16],
    input  logic                  i_clr,
    output logic                  o_done,
    output logic [63:0]           o_hash [8]
);
    import sha512_pkg::*;

    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [16];
    logic [6:0]  r_t;
    logic        r_run, r_fin;

    logic [63:0] w_t, s0, s1, t1, t2, e, a;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    always_comb begin
        e   = r_v[4];
        a   = r_v[0];
        s1  = rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        s0  = rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        w_t = r_w[0];
        t1  = r_v[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
            + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(r_t) + w_t;
        t2  = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
            + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // r_w[0] always holds w[t]; new word w[t+16] computed from w[t..t+15]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
            r_t   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            r_fin <= 1'b0;
            if (i_clr) begin
                for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
            end
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_t   <= '0;
                for (int i = 0; i < 16; i++) r_w[i] <= i_w[i];
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end else if (r_run) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= s1 + r_w[9] + s0 + r_w[0];
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_t    <= r_t + 7'd1;
                if (r_t == 7'(ROUNDS - 1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_done = !r_run && !r_fin && !i_ctl.start;
    assign o_hash = r_h;

endmodule

// ----- design/sha512_hash_engine.sv -----
// sha512_hash_engine: top level, word buffering, padding and digest output
// depends on sha512_pkg, sha512_core
// the word that fills a block is followed by o_stall while the block is compressed
// final word: the rest of the message is padded and compressed, then 8 beats out
// no word is taken while a block compresses in the one-round-a-cycle loop of sha512_core
// reset: synchronous active low, hash returns to the initial value, counts clear
module sha512_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_msg_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_final_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);
    import sha512_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_buf [16];
    logic [3:0]  r_pos;
    logic [31:0] r_bytes;
    logic        r_pad_first, r_fin;
    logic        r_full, r_len, r_zero14;
    logic [2:0]  r_oidx;
    t_core_ctl   ctl;
    logic        core_done, clr, acc;
    logic [63:0] hash [8];
    logic [63:0] pad_word, mask, last_word;
    logic [3:0]  nb;
    logic [32:0] bsum;

    sha512_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_w(r_buf),
        .i_clr(clr), .o_done(core_done), .o_hash(hash)
    );

    assign acc = i_valid && !o_stall;
    assign nb  = !i_final_word ? 4'd8 : (i_valid_bytes > 4'd8 ? 4'd8 : i_valid_bytes);
    assign bsum = {1'b0, r_bytes} + {29'd0, nb};

    always_comb begin
        mask = '1;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= nb) mask[63 - 8*i -: 8] = 8'h00;
        end
        last_word = i_msg_word & mask;
        if (nb != 4'd8) last_word[63 - 8*nb -: 8] = 8'h80;
        if (r_pad_first) pad_word = 64'h8000_0000_0000_0000;
        else if (r_pos == 4'd15 && r_zero14) pad_word = {29'd0, r_bytes, 3'b000};
        else pad_word = '0;
    end

    always_comb begin
        n_state    = r_state;
        ctl.start  = 1'b0;
        clr        = 1'b0;
        o_stall    = (r_state != ST_IDLE);
        o_valid    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc && (i_final_word || r_pos == 4'd15)) n_state = ST_PAD;
            end
            ST_PAD: begin
                if (r_full) begin
                    ctl.start = 1'b1;
                    n_state   = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (core_done) begin
                    if (!r_fin) n_state = ST_IDLE;
                    else if (r_len) n_state = ST_OUT;
                    else n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall && r_oidx == 3'd7) begin
                    clr     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // r_fin: final word taken, digest still owed; r_full: block ready to compress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_bytes     <= '0;
            r_pad_first <= 1'b0;
            r_fin       <= 1'b0;
            r_full      <= 1'b0;
            r_len       <= 1'b0;
            r_zero14    <= 1'b0;
            r_oidx      <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_bytes <= bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
                        r_pos   <= r_pos + 4'd1;
                        r_buf[r_pos] <= i_final_word ? last_word : i_msg_word;
                        if (r_pos == 4'd15) r_full <= 1'b1;
                        if (i_final_word) begin
                            r_fin       <= 1'b1;
                            r_pad_first <= (nb == 4'd8);
                        end
                    end
                end
                ST_PAD: begin
                    if (r_full) begin
                        r_full <= 1'b0;
                    end else begin
                        r_buf[r_pos] <= pad_word;
                        r_pos        <= r_pos + 4'd1;
                        r_pad_first  <= 1'b0;
                        if (r_pos == 4'd15) begin
                            r_full <= 1'b1;
                            if (r_zero14 && !r_pad_first) r_len <= 1'b1;
                        end
                        if (r_pos == 4'd14 && !r_pad_first) r_zero14 <= 1'b1;
                    end
                end
                ST_ROUND: begin
                    if (core_done && r_fin && r_len) r_oidx <= '0;
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_bytes  <= '0;
                            r_pos    <= '0;
                            r_fin    <= 1'b0;
                            r_len    <= 1'b0;
                            r_zero14 <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_digest_word  = hash[r_oidx];
    assign o_digest_index = r_oidx;
    assign o_digest_last  = (r_oidx == 3'd7);

endmodule

// ----- dv/sha512_digest_checker.sv -----
// sha512_digest_checker: watches both channels of sha512_hash_engine, computes
// the expected sha-512 digests and compares every output beat against them
// depends on sha512_pkg for the initial hash value
module sha512_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [63:0] i_msg_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_final_word,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [63:0] o_digest_word,
    input  logic [2:0]  o_digest_index,
    input  logic        o_digest_last,
    output int          o_fail_count,
    output int          o_digest_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sha512_pkg::*;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    localparam logic [63:0] KTAB [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    logic [63:0]  hash_state [8];
    logic [63:0]  msg_block [16];
    int unsigned  fill_pos;
    logic [31:0]  msg_bytes;
    t_digest_beat digest_queue [$];
    int           fails;
    int           digests;
    int           pend;

    assign o_fail_count   = fails;
    assign o_digest_count = digests;
    assign o_pending      = pend;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wt, t1, t2, a2, a15;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                a2  = w[(t - 2) & 15];
                a15 = w[(t - 15) & 15];
                wt = (ror64(a2, 19) ^ ror64(a2, 61) ^ (a2 >> 6)) + w[(t - 7) & 15]
                   + (ror64(a15, 1) ^ ror64(a15, 8) ^ (a15 >> 7)) + w[t & 15];
                w[t & 15] = wt;
            end
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + wt;
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic append_word(logic [63:0] w);
        msg_block[fill_pos] = w;
        fill_pos = (fill_pos + 1) & 15;
        if (fill_pos == 0) compress_block();
    endtask

    task automatic count_bytes(int unsigned n);
        if (msg_bytes > 32'hFFFF_FFFF - n) msg_bytes = 32'hFFFF_FFFF;
        else msg_bytes += n;
    endtask

    task automatic take_word(logic [63:0] word, logic [3:0] nb, logic fin);
        int unsigned  n;
        logic [63:0]  keep;
        t_digest_beat b;
        if (!fin) begin
            count_bytes(8);
            append_word(word);
            return;
        end
        n = (nb > 8) ? 8 : nb;
        count_bytes(n);
        if (n == 8) begin
            append_word(word);
            append_word(64'h80 << 56);
        end else begin
            keep = (n == 0) ? 64'd0 : ({64{1'b1}} << (64 - 8 * n));
            append_word((word & keep) | (64'h80 << (56 - 8 * n)));
        end
        while (fill_pos != 14) append_word(64'd0);
        append_word(64'd0);
        append_word({29'd0, msg_bytes, 3'd0});
        for (int k = 0; k < 8; k++) begin
            b.word  = hash_state[k];
            b.index = k[2:0];
            b.last  = (k == 7);
            digest_queue.push_back(b);
            hash_state[k] = IV[k];
        end
        msg_bytes = 0;
        fill_pos  = 0;
    endtask

    always @(posedge i_clk) begin
        t_digest_beat e;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
            fill_pos  = 0;
            msg_bytes = 0;
        end else begin
            if (i_valid && !o_stall) take_word(i_msg_word, i_valid_bytes, i_final_word);
            if (o_valid && !i_stall) begin
                if (digest_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected digest beat %h", o_digest_word);
                end else begin
                    e = digest_queue.pop_front();
                    digests++;
                    if (e.word !== o_digest_word || e.index !== o_digest_index
                        || e.last !== o_digest_last) begin
                        fails++;
                        if (fails <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     e.word, e.index, e.last,
                                     o_digest_word, o_digest_index, o_digest_last);
                    end
                end
            end
        end
        pend = digest_queue.size();
    end

    initial begin
        fails   = 0;
        digests = 0;
        pend    = 0;
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
        fill_pos  = 0;
        msg_bytes = 0;
    end
endmodule

// ----- dv/sha512_hash_engine_tb.sv -----
// sha512_hash_engine_tb: drives messages of random length into the hash engine
// with bursty input and random output stall; verdict from sha512_digest_checker
// depends on sha512_pkg, sha512_hash_engine, sha512_digest_checker
module sha512_hash_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_msg_word;
    logic [3:0]  i_valid_bytes;
    logic        i_final_word;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_digest_word;
    logic [2:0]  o_digest_index;
    logic        o_digest_last;
    int          fail_count;
    int          digest_count;
    int          pending;
    int          idle_cycles;
    int          words_sent;
    int          msgs_sent;
    int          stall_mode;

    sha512_hash_engine uut (.*);

    sha512_digest_checker chk (
        .*,
        .o_fail_count  (fail_count),
        .o_digest_count(digest_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stall pattern, with quiet stretches
    always @(negedge i_clk) begin
        if (($urandom_range(0, 199)) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_beat(logic [63:0] w, logic [3:0] nb, logic fin);
        i_valid       <= 1'b1;
        i_msg_word    <= w;
        i_valid_bytes <= nb;
        i_final_word  <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
        if (fin) msgs_sent++;
        @(negedge i_clk);
    endtask

    task automatic gap_maybe();
        int g;
        if ($urandom_range(0, 5) == 0) begin
            g = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic send_message(int nwords, logic [3:0] last_nb, bit rand_nb);
        for (int i = 0; i < nwords; i++) begin
            send_beat({$urandom, $urandom},
                      rand_nb ? 4'($urandom_range(0, 15)) : 4'd8, 1'b0);
            gap_maybe();
        end
        send_beat({$urandom, $urandom}, last_nb, 1'b1);
        gap_maybe();
    endtask

    initial begin
        i_rst_n = 0; i_valid = 0; i_stall = 0; stall_mode = 0;
        i_msg_word = '0; i_valid_bytes = '0; i_final_word = 0;
        idle_cycles = 0; words_sent = 0; msgs_sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // empty message, extremes of valid bytes, block boundaries
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
        send_beat(64'd0, 4'd8, 1'b1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
        send_beat(64'h0123_4567_89AB_CDEF, 4'd7, 1'b1);
        send_message(13, 4'd8, 1'b1);
        send_message(14, 4'd0, 1'b0);
        send_message(15, 4'd3, 1'b0);
        send_message(15, 4'd8, 1'b0);
        send_message(16, 4'd9, 1'b1);

        // hold off until every digest beat has come out
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        while (words_sent < 520) begin
            send_message(($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(0, 17),
                         4'($urandom_range(0, 15)), 1'b1);
            if ($urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(5, 40)) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("sent %0d words in %0d messages, checked %0d digest beats",
                 words_sent, msgs_sent, digest_count);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
